// ===== hdl/itp_pkg.sv =====
package itp_pkg;

  localparam int CNT_W = 6;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  // Stack entry codes.
  localparam logic [2:0] CODE_PLUS  = 3'd0;
  localparam logic [2:0] CODE_MINUS = 3'd1;
  localparam logic [2:0] CODE_MUL   = 3'd2;
  localparam logic [2:0] CODE_DIV   = 3'd3;
  localparam logic [2:0] CODE_OPEN  = 3'd4;

  localparam logic [1:0] ST_OK              = 2'd0;
  localparam logic [1:0] ST_OVERFLOW        = 2'd1;
  localparam logic [1:0] ST_UNMATCHED_CLOSE = 2'd2;
  localparam logic [1:0] ST_UNMATCHED_OPEN  = 2'd3;

  typedef enum logic [1:0] {
    CLS_OPERAND,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPERATOR
  } sym_class_t;

  typedef struct packed {
    logic       capture;
    logic       emit;
    logic       emit_top;
    logic       push;
    logic       pop;
    logic       finish;
    logic [1:0] err_set;
  } cmd_t;

  typedef struct packed {
    sym_class_t cls;
    logic       count_zero;
    logic       count_full;
    logic       top_open;
    logic       top_ge;
    logic       final_sym;
    logic       pend_valid;
    logic       out_free;
  } stat_t;

  function automatic sym_class_t class_of(input logic [7:0] c);
    sym_class_t r;
    case (c)
      CH_OPEN:  r = CLS_OPEN;
      CH_CLOSE: r = CLS_CLOSE;
      CH_PLUS, CH_MINUS, CH_MUL, CH_DIV: r = CLS_OPERATOR;
      default:  r = CLS_OPERAND;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] code_of(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      CH_PLUS:  r = CODE_PLUS;
      CH_MINUS: r = CODE_MINUS;
      CH_MUL:   r = CODE_MUL;
      CH_DIV:   r = CODE_DIV;
      default:  r = CODE_OPEN;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] char_of(input logic [2:0] code);
    logic [7:0] r;
    case (code)
      CODE_PLUS:  r = CH_PLUS;
      CODE_MINUS: r = CH_MINUS;
      CODE_MUL:   r = CH_MUL;
      CODE_DIV:   r = CH_DIV;
      default:    r = CH_OPEN;
    endcase
    return r;
  endfunction

  function automatic logic rank_hi(input logic [2:0] code);
    return (code == CODE_MUL) || (code == CODE_DIV);
  endfunction

endpackage

// ===== hdl/itp_char_if.sv =====
interface itp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       final_symbol;

  modport source (output valid, output symbol, output final_symbol, input ready);
  modport sink   (input valid, input symbol, input final_symbol, output ready);
endinterface

// ===== hdl/itp_result_if.sv =====
interface itp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       symbol_valid;
  logic       expression_end;
  logic       run_last;
  logic [1:0] status;

  modport source (output valid, output out_symbol, output symbol_valid,
                  output expression_end, output run_last, output status, input ready);
  modport sink   (input valid, input out_symbol, input symbol_valid,
                  input expression_end, input run_last, input status, output ready);
endinterface

// ===== hdl/itp_ram.sv =====
module itp_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/itp_dp.sv =====
module itp_dp #(
  parameter int STACK_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  itp_pkg::cmd_t  cmd,
  output itp_pkg::stat_t stat,
  input  logic [7:0]   symbol,
  input  logic         final_symbol,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [7:0]   out_symbol,
  output logic         symbol_valid,
  output logic         expression_end,
  output logic         run_last,
  output logic [1:0]   status
);
  import itp_pkg::*;

  localparam int ADDR_W = $clog2(STACK_DEPTH);

  logic [7:0]       sym_q;
  logic             final_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       err;
  logic             pend_valid;
  logic [7:0]       pend_char;
  logic             fwd;
  logic [2:0]       fwd_data;
  logic [2:0]       rd_data;
  logic [2:0]       top;
  logic [2:0]       sym_code;
  logic [2:0]       push_code;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic             out_free;

  assign sym_code  = code_of(sym_q);
  assign push_code = (class_of(sym_q) == CLS_OPEN) ? CODE_OPEN : sym_code;
  assign top       = fwd ? fwd_data : rd_data;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    count_next = count;
    if (cmd.finish && final_q) begin
      count_next = '0;
    end else if (cmd.push) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  // The read address always follows the next top of stack, so the top entry is
  // ready in the cycle after any push or pop.
  assign rd_addr = ADDR_W'(count_next - CNT_W'(1));
  assign wr_addr = ADDR_W'(count);

  itp_ram #(
    .WIDTH (3),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (wr_addr),
    .wr_data (push_code),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    stat.cls        = class_of(sym_q);
    stat.count_zero = (count == '0);
    stat.count_full = (count >= CNT_W'(STACK_DEPTH));
    stat.top_open   = (top == CODE_OPEN);
    stat.top_ge     = rank_hi(top) || !rank_hi(sym_code);
    stat.final_sym  = final_q;
    stat.pend_valid = pend_valid;
    stat.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sym_q   <= symbol;
      final_q <= final_symbol;
    end
    fwd_data <= push_code;
    if (cmd.emit) begin
      pend_char <= cmd.emit_top ? char_of(top) : sym_q;
    end
    if (cmd.finish) begin
      out_symbol     <= pend_valid ? pend_char : 8'h00;
      symbol_valid   <= pend_valid;
      run_last       <= 1'b1;
      expression_end <= final_q;
      status         <= final_q ? err : ST_OK;
    end else if (cmd.emit && pend_valid) begin
      out_symbol     <= pend_char;
      symbol_valid   <= 1'b1;
      run_last       <= 1'b0;
      expression_end <= 1'b0;
      status         <= ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      err        <= ST_OK;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      fwd        <= 1'b0;
    end else begin
      count <= count_next;
      fwd   <= cmd.push && (wr_addr == rd_addr);
      if (cmd.finish && final_q) begin
        err <= ST_OK;
      end else if (err == ST_OK) begin
        err <= cmd.err_set;
      end
      if (cmd.finish) begin
        pend_valid <= 1'b0;
      end else if (cmd.emit) begin
        pend_valid <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= pend_valid || final_q;
      end else if (cmd.emit && pend_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.count_full)
    else $error("push on a full stack");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.count_zero)
    else $error("pop on an empty stack");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && pend_valid) || cmd.finish |-> out_free)
    else $error("result register overwritten before it was taken");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && final_q |=> count == '0 && err == ST_OK && !pend_valid)
    else $error("state not cleared at expression end");
`endif

endmodule

// ===== hdl/itp_ctrl.sv =====
module itp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  itp_pkg::stat_t stat,
  output itp_pkg::cmd_t  cmd
);
  import itp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROC  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_emit;

  // A new character may be held once the previous one can move on.
  assign can_emit = !stat.pend_valid || stat.out_free;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_PROC;
        end
      end
      S_PROC: begin
        case (stat.cls)
          CLS_OPERAND: begin
            if (can_emit) begin
              cmd.emit   = 1'b1;
              state_next = S_FLUSH;
            end
          end
          CLS_OPEN: begin
            if (stat.count_full) begin
              cmd.err_set = ST_OVERFLOW;
            end else begin
              cmd.push = 1'b1;
            end
            state_next = S_FLUSH;
          end
          CLS_CLOSE: begin
            if (stat.count_zero) begin
              cmd.err_set = ST_UNMATCHED_CLOSE;
              state_next  = S_FLUSH;
            end else if (stat.top_open) begin
              cmd.pop    = 1'b1;
              state_next = S_FLUSH;
            end else if (can_emit) begin
              cmd.emit     = 1'b1;
              cmd.emit_top = 1'b1;
              cmd.pop      = 1'b1;
            end
          end
          CLS_OPERATOR: begin
            if (!stat.count_zero && !stat.top_open && stat.top_ge) begin
              if (can_emit) begin
                cmd.emit     = 1'b1;
                cmd.emit_top = 1'b1;
                cmd.pop      = 1'b1;
              end
            end else begin
              if (stat.count_full) begin
                cmd.err_set = ST_OVERFLOW;
              end else begin
                cmd.push = 1'b1;
              end
              state_next = S_FLUSH;
            end
          end
          default: begin
            state_next = S_FLUSH;
          end
        endcase
      end
      S_FLUSH: begin
        if (stat.final_sym && !stat.count_zero) begin
          if (stat.top_open) begin
            cmd.pop     = 1'b1;
            cmd.err_set = ST_UNMATCHED_OPEN;
          end else if (can_emit) begin
            cmd.emit     = 1'b1;
            cmd.emit_top = 1'b1;
            cmd.pop      = 1'b1;
          end
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_PROC)
    else $error("request captured without starting work");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> in_ready)
    else $error("block not ready after finishing a request");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop) && !(cmd.emit && cmd.finish))
    else $error("conflicting datapath commands");
`endif

endmodule

// ===== hdl/infix_to_postfix_converter.sv =====
// Shunting-yard infix to postfix converter. Each request carries one ASCII character;
// operands pass through, parentheses and + - * / go through an operator stack of
// STACK_DEPTH entries held in a RAM with registered read. A request is captured, worked
// through and flushed, and pops stack entries on the way (an operator taken off by a
// closing parenthesis or by an operator of lower or equal rank, or any entry on the
// flush of the final character). The opening parenthesis that a closing one matches is
// popped as the work on the closing one ends. The controller steps through the stack one
// entry per cycle while results can move on; a result side that holds off stalls it.
// Results are held one deep so the last result of each request can carry run_last, and
// the final character's last result carries expression_end and the status (ok,
// overflow, unmatched close, unmatched open). A final character that produces nothing
// yields one empty marker.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input logic         clk,
  input logic         rst,
  itp_char_if.sink    chars,
  itp_result_if.source postfix
);
  import itp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_ready (chars.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itp_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .symbol         (chars.symbol),
    .final_symbol   (chars.final_symbol),
    .out_ready      (postfix.ready),
    .out_valid      (postfix.valid),
    .out_symbol     (postfix.out_symbol),
    .symbol_valid   (postfix.symbol_valid),
    .expression_end (postfix.expression_end),
    .run_last       (postfix.run_last),
    .status         (postfix.status)
  );

endmodule
